// ===== rtl/stup_pkg.sv =====
// ----------------------------------------------------------------------------
// String to unsigned parser package
// Phase and status codes, character constants and the digit decoder.
// ----------------------------------------------------------------------------
package stup_pkg;

  localparam int unsigned MAX_STRING_LEN = 32'd65535;
  localparam int unsigned LIMIT_INT      = (MAX_STRING_LEN < 65535) ? MAX_STRING_LEN : 65535;
  localparam logic [15:0] LIMIT          = 16'(LIMIT_INT);

  localparam logic [5:0] BASE_RESET = 6'd10;
  localparam logic [5:0] BASE_AUTO  = 6'd0;
  localparam logic [5:0] BASE_BAD   = 6'd1;
  localparam logic [5:0] BASE_BIN   = 6'd2;
  localparam logic [5:0] BASE_OCT   = 6'd8;
  localparam logic [5:0] BASE_DEC   = 6'd10;
  localparam logic [5:0] BASE_HEX   = 6'd16;
  localparam logic [5:0] BASE_MAX   = 6'd36;
  localparam logic [5:0] NO_DIGIT   = 6'd36;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_SIGNED,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_DIGITS,
    ST_OVERFLOW,
    ST_BAD_BASE
  } status_t;

  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [5:0] d;
    d = NO_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) d = 6'(c - CH_ZERO);
    else if (c >= CH_LA && c <= CH_LZ) d = 6'(c - CH_LA) + 6'd10;
    else if (c >= CH_UA && c <= CH_UZ) d = 6'(c - CH_UA) + 6'd10;
    return d;
  endfunction

endpackage

// ===== rtl/string_to_unsigned_parser.sv =====
// ----------------------------------------------------------------------------
// String to unsigned parser
// Streaming strtoul-style numeral converter, one character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Characters arrive on the in_valid/in_ready channel (ch, first). A
//   character with first high starts a new string and samples base_setting.
//   Results (value, end_offset, status) leave on out_valid/out_ready, at most
//   one per string, on the terminating non-digit, on overflow or on a bad base.
//   cfg_we/cfg_data write base_setting; change it only when idle.
//   A result is valid the cycle after the character that ends the string
//   is transferred. Throughput: one character per cycle while results are
//   taken; the step is one 64x6 multiply-add with overflow check between
//   the input and the result register.
//   A stalled receiver holds the result register; in_ready then stays low
//   until the result is taken (in_ready = !out_valid | out_ready).
//   Reset: base 10, parser waits for a character flagged first, no result.
// ----------------------------------------------------------------------------
module string_to_unsigned_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        first,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value,
  output logic [15:0] end_offset,
  output logic [1:0]  status
);
  import stup_pkg::*;

  logic [5:0]  base_setting;
  phase_t      phase, phase_next;
  logic [63:0] acc, acc_next;
  logic        minus_seen, minus_next;
  logic [5:0]  active_base, base_next;
  logic [15:0] char_position, pos_next;
  logic        finished, finished_next;

  logic        emit;
  logic [63:0] res_value;
  logic [15:0] res_end;
  status_t     res_status;
  logic [7:0]  c;
  logic [5:0]  d;
  logic [5:0]  eff;
  logic        step;
  logic [69:0] prod;
  logic        accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_next    = phase;
    acc_next      = acc;
    minus_next    = minus_seen;
    base_next     = active_base;
    pos_next      = char_position;
    finished_next = finished;
    emit          = 1'b0;
    res_value     = '0;
    res_end       = '0;
    res_status    = ST_OK;
    step          = 1'b0;

    if (first) begin
      phase_next    = PH_SKIP;
      acc_next      = '0;
      minus_next    = 1'b0;
      base_next     = base_setting;
      pos_next      = '0;
      finished_next = 1'b0;
      if (base_setting == BASE_BAD || base_setting > BASE_MAX) begin
        emit          = 1'b1;
        res_status    = ST_BAD_BASE;
        finished_next = 1'b1;
      end
    end

    c   = (pos_next >= LIMIT) ? CH_NUL : ch;
    d   = digit_of(c);
    eff = (base_next == BASE_AUTO) ? BASE_DEC : base_next;

    if (!finished_next) begin
      case (phase_next)
        PH_SKIP, PH_SIGNED: begin
          if (phase_next == PH_SKIP &&
              (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
            // whitespace, skip
          end else if (phase_next == PH_SKIP && (c == CH_PLUS || c == CH_MINUS)) begin
            minus_next = (c == CH_MINUS);
            phase_next = PH_SIGNED;
          end else if (c == CH_ZERO && (base_next == BASE_AUTO || base_next == BASE_BIN ||
                                         base_next == BASE_HEX)) begin
            acc_next   = '0;
            phase_next = PH_ZERO;
          end else if (d < eff) begin
            base_next = eff;
            step      = 1'b1;
          end else begin
            emit          = 1'b1;
            res_status    = ST_NO_DIGITS;
            finished_next = 1'b1;
          end
        end
        PH_ZERO: begin
          if ((c == CH_LX || c == CH_UX) &&
              (base_next == BASE_AUTO || base_next == BASE_HEX)) begin
            base_next  = BASE_HEX;
            phase_next = PH_PREFIX;
          end else if ((c == CH_LB || c == CH_UB) &&
                       (base_next == BASE_AUTO || base_next == BASE_BIN)) begin
            base_next  = BASE_BIN;
            phase_next = PH_PREFIX;
          end else begin
            if (base_next == BASE_AUTO) base_next = BASE_OCT;
            step = 1'b1;
          end
        end
        PH_PREFIX: begin
          if (d < base_next) begin
            step = 1'b1;
          end else begin
            // prefix with no digits: the leading zero is the numeral
            emit          = 1'b1;
            res_end       = pos_next - 16'd1;
            finished_next = 1'b1;
          end
        end
        default: begin
          step = 1'b1;
        end
      endcase
    end

    prod = 70'(acc_next) * 70'(base_next) + 70'(d);

    if (step) begin
      if (base_next >= BASE_BIN && d < base_next) begin
        if (|prod[69:64]) begin
          emit          = 1'b1;
          res_status    = ST_OVERFLOW;
          finished_next = 1'b1;
        end else begin
          acc_next   = prod[63:0];
          phase_next = PH_DIGITS;
        end
      end else begin
        emit          = 1'b1;
        res_value     = minus_next ? (64'd0 - acc_next) : acc_next;
        res_end       = pos_next;
        finished_next = 1'b1;
      end
    end

    if (!finished_next && pos_next != 16'hFFFF) pos_next = pos_next + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_setting  <= BASE_RESET;
      phase         <= PH_SKIP;
      acc           <= '0;
      minus_seen    <= 1'b0;
      active_base   <= '0;
      char_position <= '0;
      finished      <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) base_setting <= cfg_data;
      if (accept) begin
        phase         <= phase_next;
        acc           <= acc_next;
        minus_seen    <= minus_next;
        active_base   <= base_next;
        char_position <= pos_next;
        finished      <= finished_next;
      end
      if (accept && emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      value      <= res_value;
      end_offset <= res_end;
      status     <= res_status;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// String to unsigned parser testbench
// Streams numerals into the parser one character per transfer. A local
// strtoul-style predictor queues the expected value, end offset and status
// for each string. Every result transfer is checked against the oldest
// entry. Both sides idle and stall at random, and one long receiver hold-off
// fills the block. The base register is changed between strings.
// ----------------------------------------------------------------------------
module tb_top;
  import stup_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [63:0] value;
    logic [15:0] end_offset;
    status_t     status;
  } numeral_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  ch = '0;
  logic        first = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] value;
  logic [15:0] end_offset;
  logic [1:0]  status;

  numeral_result_t expected_numerals[$];

  // predictor state
  phase_t      scan_phase = PH_SKIP;
  logic [63:0] scan_acc = '0;
  bit          scan_minus = 1'b0;
  logic [5:0]  scan_base = '0;
  logic [15:0] scan_pos = '0;
  bit          scan_done = 1'b1;
  logic [5:0]  base_reg = BASE_RESET;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int chars_taken = 0;
  int results_seen = 0;
  int base_writes = 0;
  int error_count = 0;
  int cycle_count = 0;

  string_to_unsigned_parser uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .first      (first),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .end_offset (end_offset),
    .status     (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [5:0] digit_value(input logic [7:0] c);
    if (c inside {[CH_ZERO:CH_NINE]}) return 6'(c - CH_ZERO);
    if (c inside {[CH_LA:CH_LZ]}) return 6'(c - CH_LA + 8'd10);
    if (c inside {[CH_UA:CH_UZ]}) return 6'(c - CH_UA + 8'd10);
    return NO_DIGIT;
  endfunction

  function automatic void close_numeral(input logic [63:0] v, input logic [15:0] e,
                                        input status_t s);
    numeral_result_t r;
    r.value = v;
    r.end_offset = e;
    r.status = s;
    expected_numerals.push_back(r);
    scan_done = 1'b1;
  endfunction

  function automatic void take_digit(input logic [7:0] c);
    logic [5:0]  d;
    logic [63:0] b;
    d = digit_value(c);
    b = 64'(scan_base);
    if (scan_base >= BASE_BIN && d < scan_base) begin
      if (scan_acc > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / b) begin
        close_numeral('0, '0, ST_OVERFLOW);
      end else begin
        scan_acc = scan_acc * b + 64'(d);
        scan_phase = PH_DIGITS;
      end
    end else begin
      close_numeral(scan_minus ? 64'd0 - scan_acc : scan_acc, scan_pos, ST_OK);
    end
  endfunction

  // returns 0 when the character is ignored
  function automatic bit scan_char(input logic [7:0] c_in, input logic f);
    logic [7:0] c;
    logic [5:0] eff;
    c = c_in;
    if (f) begin
      scan_phase = PH_SKIP;
      scan_acc = '0;
      scan_minus = 1'b0;
      scan_base = base_reg;
      scan_pos = '0;
      scan_done = 1'b0;
      if (base_reg == BASE_BAD || base_reg > BASE_MAX) begin
        close_numeral('0, '0, ST_BAD_BASE);
        return 1'b1;
      end
    end
    if (scan_done) return 1'b0;
    if (scan_pos >= LIMIT) c = CH_NUL;
    case (scan_phase)
      PH_SKIP, PH_SIGNED: begin
        if (scan_phase == PH_SKIP && (c == CH_SPACE || c inside {[CH_TAB:CH_CR]})) begin
          // leading whitespace
        end else if (scan_phase == PH_SKIP && (c == CH_PLUS || c == CH_MINUS)) begin
          scan_minus = (c == CH_MINUS);
          scan_phase = PH_SIGNED;
        end else if (c == CH_ZERO && (scan_base == BASE_AUTO || scan_base == BASE_BIN ||
                                      scan_base == BASE_HEX)) begin
          scan_acc = '0;
          scan_phase = PH_ZERO;
        end else begin
          eff = (scan_base == BASE_AUTO) ? BASE_DEC : scan_base;
          if (digit_value(c) < eff) begin
            scan_base = eff;
            take_digit(c);
          end else begin
            close_numeral('0, '0, ST_NO_DIGITS);
          end
        end
      end
      PH_ZERO: begin
        if ((c == CH_LX || c == CH_UX) && (scan_base == BASE_AUTO || scan_base == BASE_HEX)) begin
          scan_base = BASE_HEX;
          scan_phase = PH_PREFIX;
        end else if ((c == CH_LB || c == CH_UB) &&
                     (scan_base == BASE_AUTO || scan_base == BASE_BIN)) begin
          scan_base = BASE_BIN;
          scan_phase = PH_PREFIX;
        end else begin
          if (scan_base == BASE_AUTO) scan_base = BASE_OCT;
          take_digit(c);
        end
      end
      PH_PREFIX: begin
        if (digit_value(c) < scan_base) take_digit(c);
        else close_numeral('0, scan_pos - 16'd1, ST_OK);
      end
      default: take_digit(c);
    endcase
    if (!scan_done && scan_pos < 16'hFFFF) scan_pos = scan_pos + 16'd1;
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------ checker
  task automatic report_error(input string msg);
    if (error_count < 50) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    numeral_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_numerals.size() == 0) begin
        report_error($sformatf("unexpected result value=%0h end=%0d status=%0d",
                               value, end_offset, status));
      end else begin
        want = expected_numerals.pop_front();
        if (value !== want.value)
          report_error($sformatf("result %0d value %0h, expected %0h",
                                 results_seen, value, want.value));
        if (end_offset !== want.end_offset)
          report_error($sformatf("result %0d end_offset %0d, expected %0d",
                                 results_seen, end_offset, want.end_offset));
        if (status !== want.status)
          report_error($sformatf("result %0d status %0d, expected %0d",
                                 results_seen, status, want.status));
      end
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_numerals.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_char(input logic [7:0] c, input logic f);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    first <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_taken++;
    void'(scan_char(c, f));
  endtask

  task automatic send_str(input string s, input bit term_on, input logic [7:0] term);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
    if (term_on) send_char(term, s.len() == 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_numerals.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(input logic [5:0] b);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= b;
    @(posedge clk);
    base_reg = b;
    base_writes++;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [5:0] pick_base();
    int r;
    r = $urandom_range(99);
    if (r < 15) return BASE_AUTO;
    if (r < 25) return BASE_BIN;
    if (r < 32) return BASE_OCT;
    if (r < 45) return BASE_DEC;
    if (r < 60) return BASE_HEX;
    if (r < 70) return BASE_MAX;
    if (r < 95) return 6'($urandom_range(2, 36));
    if (r < 97) return BASE_BAD;
    return 6'($urandom_range(37, 63));
  endfunction

  // well-formed numeral with random content for the current base
  task automatic send_numeral();
    string      s;
    int         db;
    int         n;
    int         k;
    int         d;
    logic [7:0] c;
    s = "";
    db = int'(base_reg);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        k = $urandom_range(5);
        c = (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
        s = $sformatf("%s%c", s, c);
      end
    end
    k = $urandom_range(3);
    if (k == 1) s = {s, "+"};
    else if (k == 2) s = {s, "-"};
    k = $urandom_range(3);
    if ((db == 0 || db == 16) && k == 0) begin
      s = {s, $urandom_range(1) ? "0x" : "0X"};
      db = 16;
    end else if ((db == 0 || db == 2) && k == 1) begin
      s = {s, $urandom_range(1) ? "0b" : "0B"};
      db = 2;
    end else if (db == 0 && k == 2) begin
      s = {s, "0"};
      db = 8;
    end else if (db == 0) begin
      db = 10;
    end
    if (db < 2 || db > 36) db = 10;
    k = $urandom_range(19);
    if (k == 0) n = 0;
    else if (k < 3) n = $urandom_range(10, 70);
    else n = $urandom_range(1, 8);
    repeat (n) begin
      d = $urandom_range(db - 1);
      if (d < 10) c = CH_ZERO + 8'(d);
      else c = ($urandom_range(1) ? CH_LA : CH_UA) + 8'(d - 10);
      s = $sformatf("%s%c", s, c);
    end
    k = $urandom_range(19);
    if (k == 0) send_str(s, 1'b0, CH_NUL);
    else if (k < 6) send_str(s, 1'b1, CH_NUL);
    else send_str(s, 1'b1, 8'($urandom_range(255)));
  endtask

  task automatic send_garbage();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) send_char(8'($urandom_range(255)), i == 0);
  endtask

  // characters without first, mostly ignored
  task automatic send_noise();
    repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(255)), 1'b0);
  endtask

  // ------------------------------------------------------------------- tests
  task automatic test_reset_values();
    send_char(CH_ZERO, 1'b0);
    send_char(8'hFF, 1'b0);
    send_str("\t-9", 1'b1, CH_LZ);
    send_char(CH_NINE, 1'b0);
  endtask

  task automatic test_bad_base();
    write_base(BASE_BAD);
    send_str("5", 1'b0, CH_NUL);
    write_base(6'h3F);
    send_str("5", 1'b0, CH_NUL);
    send_char(CH_ZERO, 1'b0);
  endtask

  task automatic test_auto_prefix();
    write_base(BASE_AUTO);
    send_str("0x", 1'b1, "g");
    send_str("-+", 1'b0, CH_NUL);
    send_str("017", 1'b1, CH_NUL);
  endtask

  task automatic test_overflow();
    write_base(BASE_MAX);
    send_str("zzzzzzzzzzzzz", 1'b0, CH_NUL);
  endtask

  // a base written mid-string only takes hold at the next first character
  task automatic test_base_change();
    write_base(BASE_DEC);
    send_str("12", 1'b0, CH_NUL);
    write_base(BASE_HEX);
    send_char(CH_LA, 1'b0);
  endtask

  task automatic test_backpressure();
    write_base(BASE_DEC);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 400;
    repeat (20) send_str($sformatf("%0d", $urandom_range(9)), 1'b1, CH_SPACE);
  endtask

  task automatic run_random(input int n_items, input int s_idle, input int r_idle);
    int target;
    int roll;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    target = chars_taken + n_items;
    while (chars_taken < target) begin
      if ($urandom_range(29) == 0) write_base(pick_base());
      roll = $urandom_range(99);
      if (roll < 80) send_numeral();
      else if (roll < 93) send_garbage();
      else send_noise();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_bad_base();
    test_auto_prefix();
    test_overflow();
    test_base_change();
    test_backpressure();
    write_base(BASE_DEC);
    run_random(450, 28, 86);
    run_random(450, 86, 28);
    run_random(460, 0, 0);
    drain();
    repeat (8) @(posedge clk);
    $display("Checked %0d results from %0d characters over %0d base settings.",
             results_seen, chars_taken, base_writes);
    $display("Bases auto to 36 and invalid, prefixes, signs, overflow and hold-off.");
    if (error_count == 0 && expected_numerals.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
